### hdl/assert_macros.svh
// Assertion macros used by triangle_mesh_area_accumulator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/tmaa_pkg.sv
package tmaa_pkg;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_MUL  = 4'b0010,
    S_ROOT = 4'b0100,
    S_ACC  = 4'b1000
  } state_t;

  typedef logic [3:0] op_t;

  localparam op_t OP_WX_P  = 4'd0;
  localparam op_t OP_WX_N  = 4'd1;
  localparam op_t OP_WY_P  = 4'd2;
  localparam op_t OP_WY_N  = 4'd3;
  localparam op_t OP_WZ_P  = 4'd4;
  localparam op_t OP_WZ_N  = 4'd5;
  localparam op_t OP_SX_HH = 4'd6;
  localparam op_t OP_SX_HL = 4'd7;
  localparam op_t OP_SX_LL = 4'd8;
  localparam op_t OP_SY_HH = 4'd9;
  localparam op_t OP_SY_HL = 4'd10;
  localparam op_t OP_SY_LL = 4'd11;
  localparam op_t OP_SZ_HH = 4'd12;
  localparam op_t OP_SZ_HL = 4'd13;
  localparam op_t OP_SZ_LL = 4'd14;
  localparam op_t OP_DRAIN = 4'd15;

  typedef struct packed {
    logic busy;
    logic done;
  } root_stat_t;

endpackage

### hdl/tmaa_if.sv
interface tmaa_in_if #(
  parameter int COORD_BITS = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] ax;
  logic signed [COORD_BITS-1:0] ay;
  logic signed [COORD_BITS-1:0] az;
  logic signed [COORD_BITS-1:0] bx;
  logic signed [COORD_BITS-1:0] by_coord;
  logic signed [COORD_BITS-1:0] bz;
  logic signed [COORD_BITS-1:0] cx;
  logic signed [COORD_BITS-1:0] cy;
  logic signed [COORD_BITS-1:0] cz;
  logic                         last_triangle;

  modport source (
    output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
    input  ready
  );
  modport sink (
    input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, last_triangle,
    output ready
  );
endinterface

interface tmaa_out_if #(
  parameter int SUM_BITS = 56
);
  logic                  valid;
  logic                  ready;
  logic [SUM_BITS-2:0]   surface_area;
  logic                  overflowed;

  modport source (output valid, surface_area, overflowed, input ready);
  modport sink (input valid, surface_area, overflowed, output ready);
endinterface

### hdl/tmaa_mul.sv
module tmaa_mul #(
  parameter int W = 18
) (
  input  logic                  clk,
  input  logic signed [W-1:0]   a,
  input  logic signed [W-1:0]   b,
  output logic signed [2*W-1:0] p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hdl/tmaa_sqrt.sv
module tmaa_sqrt #(
  parameter int RW = 35
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [2*RW-1:0]          radicand,
  output logic [RW-1:0]            root,
  output tmaa_pkg::root_stat_t     stat
);
  import tmaa_pkg::*;

  localparam int CW = $clog2(RW + 1);

  logic [2*RW-1:0] rad;
  logic [RW+1:0]   rem;
  logic [CW-1:0]   cnt;
  logic            busy;
  logic            done;
  logic [RW+1:0]   rem_sh;
  logic [RW+1:0]   trial;
  logic            fits;

  assign rem_sh = {rem[RW-1:0], rad[2*RW-1:2*RW-2]};
  assign trial  = {root, 2'b01};
  assign fits   = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(1));
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(RW);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[2*RW-3:0], 2'b00};
      if (fits) begin
        rem  <= rem_sh - trial;
        root <= {root[RW-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[RW-2:0], 1'b0};
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

### hdl/triangle_mesh_area_accumulator.sv
// The sequencer accepts an item only while idle, so the next item waits until
// the current one has made its fifteen passes through the shared multiplier,
// run the one-bit-per-cycle square root and been accumulated.
// A waiting result does not block the next item unless that item also ends a mesh.
// Synchronous reset clears the running sum, the saturation flag and the sequencer.
`include "assert_macros.svh"

module triangle_mesh_area_accumulator #(
  parameter int COORD_BITS = 16,
  parameter int SUM_BITS   = 56
) (
  input logic clk,
  input logic rst,
  tmaa_in_if.sink    tri_in,
  tmaa_out_if.source area_out
);
  import tmaa_pkg::*;

  localparam int DW    = COORD_BITS + 1;
  localparam int MW    = COORD_BITS + 2;
  localparam int PW    = 2 * MW;
  localparam int H     = COORD_BITS + 1;
  localparam int WW    = 2 * H;
  localparam int RW    = 2 * COORD_BITS + 3;
  localparam int SQW   = 2 * RW;
  localparam int ADD_W = ((RW > SUM_BITS) ? RW : SUM_BITS) + 1;

  state_t               state;
  op_t                  cnt;
  op_t                  op_d;
  logic                 last;
  logic signed [DW-1:0] ux, uy, uz, vx, vy, vz;
  logic [WW-1:0]        wx, wy, wz;
  logic signed [PW-1:0] term;
  logic [SQW-1:0]       sq;
  logic [SUM_BITS-1:0]  sum;
  logic                 sat;

  logic signed [MW-1:0] op_a, op_b;
  logic signed [PW-1:0] prod;
  logic signed [PW:0]   diff;
  logic [PW:0]          mag;
  logic [SQW-1:0]       pp;
  logic [SQW-1:0]       sq_next;
  logic                 root_start;
  logic [RW-1:0]        root;
  root_stat_t           root_stat;
  logic [ADD_W-1:0]     sum_ext;
  logic                 ovf;
  logic [SUM_BITS-1:0]  sum_new;
  logic                 sat_new;
  logic                 out_free;

  function automatic logic signed [MW-1:0] hi_half(input logic [WW-1:0] w);
    return $signed({1'b0, w[WW-1:H]});
  endfunction

  function automatic logic signed [MW-1:0] lo_half(input logic [WW-1:0] w);
    return $signed({1'b0, w[H-1:0]});
  endfunction

  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cnt)
      OP_WX_P:  begin op_a = MW'(uy); op_b = MW'(vz); end
      OP_WX_N:  begin op_a = MW'(uz); op_b = MW'(vy); end
      OP_WY_P:  begin op_a = MW'(uz); op_b = MW'(vx); end
      OP_WY_N:  begin op_a = MW'(ux); op_b = MW'(vz); end
      OP_WZ_P:  begin op_a = MW'(ux); op_b = MW'(vy); end
      OP_WZ_N:  begin op_a = MW'(uy); op_b = MW'(vx); end
      OP_SX_HH: begin op_a = hi_half(wx); op_b = hi_half(wx); end
      OP_SX_HL: begin op_a = hi_half(wx); op_b = lo_half(wx); end
      OP_SX_LL: begin op_a = lo_half(wx); op_b = lo_half(wx); end
      OP_SY_HH: begin op_a = hi_half(wy); op_b = hi_half(wy); end
      OP_SY_HL: begin op_a = hi_half(wy); op_b = lo_half(wy); end
      OP_SY_LL: begin op_a = lo_half(wy); op_b = lo_half(wy); end
      OP_SZ_HH: begin op_a = hi_half(wz); op_b = hi_half(wz); end
      OP_SZ_HL: begin op_a = hi_half(wz); op_b = lo_half(wz); end
      OP_SZ_LL: begin op_a = lo_half(wz); op_b = lo_half(wz); end
      default:  begin op_a = '0; op_b = '0; end
    endcase
  end

  tmaa_mul #(.W(MW)) u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .p   (prod)
  );

  assign op_d = cnt - op_t'(1);
  assign diff = (PW + 1)'(term) - (PW + 1)'(prod);
  assign mag  = diff[PW] ? (PW + 1)'(-diff) : diff;

  always_comb begin
    pp = SQW'(prod[WW-1:0]);
    unique case (op_d)
      OP_SX_HH, OP_SY_HH, OP_SZ_HH: sq_next = sq + (pp << (2 * H));
      OP_SX_HL, OP_SY_HL, OP_SZ_HL: sq_next = sq + (pp << (H + 1));
      OP_SX_LL, OP_SY_LL, OP_SZ_LL: sq_next = sq + pp;
      default:                      sq_next = sq;
    endcase
  end

  assign root_start = (state == S_MUL) && (cnt == OP_DRAIN);

  tmaa_sqrt #(.RW(RW)) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (root_start),
    .radicand (sq_next),
    .root     (root),
    .stat     (root_stat)
  );

  assign sum_ext  = ADD_W'(sum) + ADD_W'(root);
  assign ovf      = sum_ext[ADD_W-1:SUM_BITS] != '0;
  assign sum_new  = ovf ? '1 : sum_ext[SUM_BITS-1:0];
  assign sat_new  = sat | ovf;
  assign out_free = !area_out.valid || area_out.ready;

  assign tri_in.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      cnt            <= OP_WX_P;
      sum            <= '0;
      sat            <= 1'b0;
      area_out.valid <= 1'b0;
    end else begin
      if (state == S_ACC && last && out_free) begin
        area_out.valid <= 1'b1;
      end else if (area_out.ready) begin
        area_out.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (tri_in.valid) begin
            state <= S_MUL;
            cnt   <= OP_WX_P;
          end
        end
        S_MUL: begin
          cnt <= cnt + op_t'(1);
          if (cnt == OP_DRAIN) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_stat.done) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (!last) begin
            sum   <= sum_new;
            sat   <= sat_new;
            state <= S_IDLE;
          end else if (out_free) begin
            sum            <= '0;
            sat            <= 1'b0;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (tri_in.valid && tri_in.ready) begin
      ux   <= DW'(tri_in.bx) - DW'(tri_in.ax);
      uy   <= DW'(tri_in.by_coord) - DW'(tri_in.ay);
      uz   <= DW'(tri_in.bz) - DW'(tri_in.az);
      vx   <= DW'(tri_in.cx) - DW'(tri_in.ax);
      vy   <= DW'(tri_in.cy) - DW'(tri_in.ay);
      vz   <= DW'(tri_in.cz) - DW'(tri_in.az);
      last <= tri_in.last_triangle;
      sq   <= '0;
    end else if (state == S_MUL && cnt != OP_WX_P) begin
      sq <= sq_next;
      unique case (op_d)
        OP_WX_P, OP_WY_P, OP_WZ_P: term <= prod;
        OP_WX_N:                   wx <= mag[WW-1:0];
        OP_WY_N:                   wy <= mag[WW-1:0];
        OP_WZ_N:                   wz <= mag[WW-1:0];
        default:                   term <= term;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_ACC && last && out_free) begin
      area_out.surface_area <= sum_new[SUM_BITS-1:1];
      area_out.overflowed   <= sat_new;
    end
  end

  `ASSERT_SAME(a_idle_root_quiet, clk, rst, tri_in.ready, !root_stat.busy)
  `ASSERT_SAME(a_done_in_root, clk, rst, root_stat.done, state == S_ROOT)
  `ASSERT_SAME(a_out_from_acc, clk, rst, $rose(area_out.valid), $past(state == S_ACC))
  `ASSERT_NEXT(a_accept_starts, clk, rst, tri_in.valid && tri_in.ready,
               state == S_MUL && cnt == OP_WX_P)

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int COORD_BITS = 16;
  localparam int SUM_BITS = 56;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 60;
  localparam int RANDOM_ITEMS = 2000;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct {
    coord_t ax, ay, az;
    coord_t bx, by_coord, bz;
    coord_t cx, cy, cz;
    logic   last_triangle;
  } tri_item_t;

  typedef struct {
    logic [SUM_BITS-2:0] surface_area;
    logic                overflowed;
  } mesh_area_t;

  typedef enum {STYLE_WIDE, STYLE_NEAR, STYLE_EDGE} coord_style_t;

  class mesh_area_scoreboard;
    logic [SUM_BITS-1:0] doubled_sum;
    bit                  saturated;
    mesh_area_t          expected_areas[$];
    int                  errors;

    function new();
      doubled_sum = '0;
      saturated = 1'b0;
      errors = 0;
    endfunction

    function logic [63:0] doubled_area(tri_item_t t);
      longint ux, uy, uz, vx, vy, vz, wx, wy, wz;
      logic [127:0] len_sq, mag, trial;
      logic [63:0] root;
      ux = longint'(t.bx) - longint'(t.ax);
      uy = longint'(t.by_coord) - longint'(t.ay);
      uz = longint'(t.bz) - longint'(t.az);
      vx = longint'(t.cx) - longint'(t.ax);
      vy = longint'(t.cy) - longint'(t.ay);
      vz = longint'(t.cz) - longint'(t.az);
      wx = uy * vz - uz * vy;
      wy = uz * vx - ux * vz;
      wz = ux * vy - uy * vx;
      len_sq = '0;
      mag = (wx < 0) ? -wx : wx;
      len_sq += mag * mag;
      mag = (wy < 0) ? -wy : wy;
      len_sq += mag * mag;
      mag = (wz < 0) ? -wz : wz;
      len_sq += mag * mag;
      root = '0;
      for (int b = 63; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= len_sq) begin
          root = trial[63:0];
        end
      end
      return root;
    endfunction

    function void note_triangle(tri_item_t t);
      logic [63:0] root;
      logic [SUM_BITS-1:0] sum_max;
      mesh_area_t done;
      sum_max = '1;
      root = doubled_area(t);
      if (root > sum_max - doubled_sum) begin
        doubled_sum = sum_max;
        saturated = 1'b1;
      end else begin
        doubled_sum = doubled_sum + root[SUM_BITS-1:0];
      end
      if (t.last_triangle) begin
        done.surface_area = doubled_sum[SUM_BITS-1:1];
        done.overflowed = saturated;
        expected_areas.push_back(done);
        doubled_sum = '0;
        saturated = 1'b0;
      end
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic [SUM_BITS-2:0] area, logic ovf);
      mesh_area_t want;
      if (expected_areas.size() == 0) begin
        report_mismatch($sformatf("unexpected result surface_area=%0d overflowed=%0b",
                                  area, ovf));
        return;
      end
      want = expected_areas.pop_front();
      if (area !== want.surface_area) begin
        report_mismatch($sformatf("surface_area %0d, expected %0d",
                                  area, want.surface_area));
      end
      if (ovf !== want.overflowed) begin
        report_mismatch($sformatf("overflowed %0b, expected %0b", ovf, want.overflowed));
      end
    endtask

    function int pending();
      return expected_areas.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   steady = 1'b0;
  int   quiet_cycles = 0;
  mesh_area_scoreboard sb;

  tmaa_in_if #(.COORD_BITS(COORD_BITS)) tri_in();
  tmaa_out_if #(.SUM_BITS(SUM_BITS)) area_out();

  triangle_mesh_area_accumulator #(
    .COORD_BITS(COORD_BITS),
    .SUM_BITS(SUM_BITS)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .tri_in(tri_in),
    .area_out(area_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic tri_item_t tri_of(coord_t ax, coord_t ay, coord_t az,
                                       coord_t bx, coord_t by_coord, coord_t bz,
                                       coord_t cx, coord_t cy, coord_t cz,
                                       logic last_triangle);
    tri_item_t t;
    t.ax = ax;
    t.ay = ay;
    t.az = az;
    t.bx = bx;
    t.by_coord = by_coord;
    t.bz = bz;
    t.cx = cx;
    t.cy = cy;
    t.cz = cz;
    t.last_triangle = last_triangle;
    return t;
  endfunction

  function automatic coord_t pick_coord(coord_style_t style, coord_t near);
    case (style)
      STYLE_WIDE: return coord_t'($urandom);
      STYLE_NEAR: return coord_t'(int'(near) + int'($urandom_range(0, 1024)) - 512);
      default: begin
        case ($urandom_range(4))
          0: return coord_t'(-32768);
          1: return coord_t'(32767);
          2: return coord_t'(0);
          3: return coord_t'(-1);
          default: return coord_t'(1);
        endcase
      end
    endcase
  endfunction

  function automatic tri_item_t random_triangle(logic last_triangle);
    tri_item_t t;
    coord_style_t style;
    int pick;
    pick = $urandom_range(9);
    style = (pick < 4) ? STYLE_WIDE : (pick < 8 || pick == 9) ? STYLE_NEAR : STYLE_EDGE;
    t.ax = pick_coord(style, coord_t'($urandom));
    t.ay = pick_coord(style, coord_t'($urandom));
    t.az = pick_coord(style, coord_t'($urandom));
    t.bx = pick_coord(style, t.ax);
    t.by_coord = pick_coord(style, t.ay);
    t.bz = pick_coord(style, t.az);
    t.cx = pick_coord(style, t.ax);
    t.cy = pick_coord(style, t.ay);
    t.cz = pick_coord(style, t.az);
    if (pick == 9) begin
      case ($urandom_range(2))
        0: begin
          t.bx = t.ax;
          t.by_coord = t.ay;
          t.bz = t.az;
        end
        1: begin
          t.cx = t.ax;
          t.cy = t.ay;
          t.cz = t.az;
        end
        default: begin
          t.cx = t.bx;
          t.cy = t.by_coord;
          t.cz = t.bz;
        end
      endcase
    end
    t.last_triangle = last_triangle;
    return t;
  endfunction

  task automatic send_triangle(tri_item_t t);
    int gap;
    gap = 0;
    while (!steady && $urandom_range(99) < 23) gap++;
    if (gap > 0) begin
      tri_in.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    tri_in.valid <= 1'b1;
    tri_in.ax <= t.ax;
    tri_in.ay <= t.ay;
    tri_in.az <= t.az;
    tri_in.bx <= t.bx;
    tri_in.by_coord <= t.by_coord;
    tri_in.bz <= t.bz;
    tri_in.cx <= t.cx;
    tri_in.cy <= t.cy;
    tri_in.cz <= t.cz;
    tri_in.last_triangle <= t.last_triangle;
    do @(posedge clk); while (!tri_in.ready);
    sb.note_triangle(t);
  endtask

  initial begin
    area_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      area_out.ready <= !rst && (steady || $urandom_range(99) >= 23);
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (area_out.valid && area_out.ready) begin
        sb.check_result(area_out.surface_area, area_out.overflowed);
      end
      if ((tri_in.valid && tri_in.ready) || (area_out.valid && area_out.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("triangle_mesh_area_accumulator test failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int random_sent;
    int mesh_len;
    sb = new();
    rst = 1'b1;
    tri_in.valid = 1'b0;
    tri_in.ax = '0;
    tri_in.ay = '0;
    tri_in.az = '0;
    tri_in.bx = '0;
    tri_in.by_coord = '0;
    tri_in.bz = '0;
    tri_in.cx = '0;
    tri_in.cy = '0;
    tri_in.cz = '0;
    tri_in.last_triangle = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_triangle(tri_of(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    send_triangle(tri_of(-32768, -32768, 0, 32767, -32768, 0, -32768, 32767, 0, 1'b1));
    send_triangle(tri_of(32767, 32767, 32767, -32768, -32768, 32767,
                         32767, -32768, -32768, 1'b0));
    send_triangle(tri_of(-32768, 32767, -32768, 32767, -32768, -32768,
                         -32768, -32768, 32767, 1'b0));
    send_triangle(tri_of(-1, -1, -1, -32768, 0, 32767, 32767, -32768, -1, 1'b1));
    send_triangle(tri_of(0, 0, 0, 256, 0, 0, 0, 256, 0, 1'b0));
    send_triangle(tri_of(0, 0, 0, 100, 200, 300, 200, 400, 600, 1'b0));
    send_triangle(tri_of(5, 6, 7, 5, 6, 7, 1000, -3, 2, 1'b1));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 1, 1'b1));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 1, 0, 1'b0));
    send_triangle(tri_of(0, 0, 0, 0, 1, 0, 0, 0, 1, 1'b0));
    send_triangle(tri_of(0, 0, 0, 1, 0, 0, 0, 0, 1, 1'b1));
    send_triangle(tri_of(-32768, -32768, -32768, -32768, -32768, -32768,
                         -32768, -32768, -32768, 1'b1));
    send_triangle(tri_of(32767, 0, -32768, -32768, 32767, 0, 0, -32768, 32767, 1'b1));

    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      mesh_len = ($urandom_range(99) < 80) ? $urandom_range(1, 8) : $urandom_range(9, 40);
      for (int i = 0; i < mesh_len; i++) begin
        steady = (random_sent >= 900 && random_sent < 1200);
        send_triangle(random_triangle(i == mesh_len - 1));
        random_sent++;
      end
    end
    steady = 1'b0;
    tri_in.valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("triangle_mesh_area_accumulator test passed");
    end else begin
      $display("triangle_mesh_area_accumulator test failed");
    end
    $finish;
  end

endmodule
